// ===== hw/rtl/script_word_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// Script word tokenizer assertion macros
// Shared property wrappers for the tokenizer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_WORD_TOKENIZER_DEFINES_SVH
`define SCRIPT_WORD_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SWT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SWT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/swt_pkg.sv =====
// ----------------------------------------------------------------------------
// Script word tokenizer package
// Character codes, result kinds, tokenizer phases and queue record types.
// ----------------------------------------------------------------------------
package swt_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LINE_W      = 16;
    localparam int unsigned RES_MAX     = 3;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RIDX_W      = $clog2(RES_MAX);

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_WEND = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_SKIP    = 2'd0,
        PH_COMMENT = 2'd1,
        PH_WORD    = 2'd2
    } phase_t;

    // One result item without its line number
    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic               cmd;
    } res_t;

    // All results caused by one input item; they share one line number
    typedef struct packed {
        logic [RIDX_W-1:0]          cnt;
        logic [LINE_W-1:0]          line;
        res_t [RES_MAX-1:0]         res;
    } bundle_t;

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_sep(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
               (c == CH_EQ) || (c == CH_COMMA);
    endfunction

endpackage

// ===== hw/rtl/swt_front.sv =====
// ----------------------------------------------------------------------------
// Script word tokenizer front end
// Accepts one text byte per cycle while the queue is not full, updates the
// tokenizer state and builds the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module swt_front import swt_pkg::*; #(
    parameter int unsigned LINE_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic                in_eob,
    input  q_stat_t             q_stat,
    output logic                push_valid,
    output bundle_t             push_data
);

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    phase_t                 phase_reg, phase_next;
    logic                   inq_reg, inq_next;
    logic                   hslash_reg, hslash_next;
    logic                   hquote_reg, hquote_next;
    logic                   colon_reg, colon_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;

    logic                   accept;
    logic                   eot;
    logic                   is_q;
    logic                   is_lf;
    logic                   do_word;
    logic                   do_fin;
    logic [RIDX_W-1:0]      n_v;
    res_t [RES_MAX-1:0]     res_v;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign eot      = (in_byte == CH_NUL) || in_eob;
    assign is_q     = (in_byte == CH_QUOTE);
    assign is_lf    = (in_byte == CH_LF);

    // Hold tokenizer state; advance on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SKIP;
            inq_reg    <= 1'b0;
            hslash_reg <= 1'b0;
            hquote_reg <= 1'b0;
            colon_reg  <= 1'b0;
            line_reg   <= LINE_ONE;
        end else if (accept) begin
            phase_reg  <= phase_next;
            inq_reg    <= inq_next;
            hslash_reg <= hslash_next;
            hquote_reg <= hquote_next;
            colon_reg  <= colon_next;
            line_reg   <= line_next;
        end
    end

    // Next state and the results of this byte
    always_comb begin
        phase_next  = phase_reg;
        inq_next    = inq_reg;
        hslash_next = hslash_reg;
        hquote_next = hquote_reg;
        colon_next  = colon_reg;
        line_next   = line_reg;
        do_word     = 1'b0;
        do_fin      = 1'b0;
        n_v         = '0;
        res_v       = '0;

        unique case (phase_reg)
            PH_WORD: begin
                if (hquote_reg) begin
                    hquote_next = 1'b0;
                    // Doubled quote inside quotes gives a literal quote
                    if (!eot && is_q) begin
                        res_v[n_v] = '{kind: KIND_BYTE, data: CH_QUOTE, cmd: 1'b0};
                        n_v        = n_v + RIDX_W'(1);
                        colon_next = 1'b0;
                    end else begin
                        inq_next = 1'b0;
                        do_word  = 1'b1;
                    end
                end else begin
                    do_word = 1'b1;
                end
            end
            PH_COMMENT: begin
                if (eot) begin
                    do_fin = 1'b1;
                end else if (is_lf) begin
                    if (line_next != '1) line_next = line_next + LINE_ONE;
                    phase_next = PH_SKIP;
                end
            end
            default: begin
                if (hslash_reg) begin
                    hslash_next = 1'b0;
                    if (!eot && (in_byte == CH_SLASH)) begin
                        phase_next = PH_COMMENT;
                    end else begin
                        // Lone slash opens a word
                        phase_next  = PH_WORD;
                        inq_next    = 1'b0;
                        hquote_next = 1'b0;
                        colon_next  = 1'b0;
                        res_v[n_v]  = '{kind: KIND_BYTE, data: CH_SLASH, cmd: 1'b0};
                        n_v         = n_v + RIDX_W'(1);
                        do_word     = 1'b1;
                    end
                end else if (eot) begin
                    do_fin = 1'b1;
                end else if (is_lf) begin
                    if (line_next != '1) line_next = line_next + LINE_ONE;
                    phase_next = PH_SKIP;
                end else if (in_byte == CH_SLASH) begin
                    phase_next  = PH_SKIP;
                    hslash_next = 1'b1;
                end else if (is_sep(in_byte)) begin
                    phase_next = PH_SKIP;
                end else begin
                    phase_next  = PH_WORD;
                    inq_next    = 1'b0;
                    hquote_next = 1'b0;
                    colon_next  = 1'b0;
                    do_word     = 1'b1;
                end
            end
        endcase

        // Process the byte as part of a word
        if (do_word) begin
            if (eot) begin
                res_v[n_v] = '{kind: KIND_WEND, data: '0, cmd: colon_next};
                n_v        = n_v + RIDX_W'(1);
                do_fin     = 1'b1;
            end else if (!inq_next && is_sep(in_byte)) begin
                res_v[n_v] = '{kind: KIND_WEND, data: '0, cmd: colon_next};
                n_v        = n_v + RIDX_W'(1);
                phase_next = PH_SKIP;
                inq_next   = 1'b0;
                if (is_lf && (line_next != '1)) line_next = line_next + LINE_ONE;
            end else if (is_q) begin
                if (inq_next) hquote_next = 1'b1;
                else          inq_next    = 1'b1;
            end else begin
                res_v[n_v] = '{kind: KIND_BYTE, data: in_byte, cmd: 1'b0};
                n_v        = n_v + RIDX_W'(1);
                colon_next = (in_byte == CH_COLON);
            end
        end

        // End of text: emit marker and return to the reset state
        if (do_fin) begin
            res_v[n_v]  = '{kind: KIND_END, data: '0, cmd: 1'b0};
            n_v         = n_v + RIDX_W'(1);
            phase_next  = PH_SKIP;
            inq_next    = 1'b0;
            hslash_next = 1'b0;
            hquote_next = 1'b0;
            colon_next  = 1'b0;
            line_next   = LINE_ONE;
        end
    end

    // Queue only items that cause results
    assign push_valid     = accept && (n_v != '0);
    assign push_data.cnt  = n_v;
    assign push_data.line = LINE_W'(line_reg);
    assign push_data.res  = res_v;

endmodule

// ===== hw/rtl/swt_queue.sv =====
// ----------------------------------------------------------------------------
// Script word tokenizer queue
// Short FIFO of result bundles between the front and back ends.
// ----------------------------------------------------------------------------
module swt_queue import swt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  bundle_t     push_data,
    input  logic        pop,
    output bundle_t     head,
    output q_stat_t     stat
);

    bundle_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_reg, rd_reg;
    logic [QCNT_W-1:0]       cnt_reg;
    logic                    do_push, do_pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_reg];

    // Store pushed bundles
    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_reg] <= push_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + QPTR_W'(1);
            if (do_pop)  rd_reg <= rd_reg + QPTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + QCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - QCNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/swt_back.sv =====
// ----------------------------------------------------------------------------
// Script word tokenizer back end
// Serializes queued bundles into result items through an output register.
// ----------------------------------------------------------------------------
module swt_back import swt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  bundle_t             head,
    input  q_stat_t             q_stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output kind_t               out_kind,
    output logic [BYTE_W-1:0]   out_byte,
    output logic [LINE_W-1:0]   out_line,
    output logic                out_cmd,
    output logic                out_last
);

    logic                   valid_reg;
    res_t                   res_reg;
    logic [LINE_W-1:0]      line_reg;
    logic                   last_reg;
    logic [RIDX_W-1:0]      idx_reg;

    logic                   load;
    logic                   is_last;
    res_t                   cur;

    assign cur     = head.res[idx_reg];
    assign is_last = (idx_reg == (head.cnt - RIDX_W'(1)));
    assign load    = (!valid_reg || out_ready) && !q_stat.empty;
    assign pop     = load && is_last;

    // Control: output valid and position inside the head bundle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= is_last ? '0 : idx_reg + RIDX_W'(1);
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload: load next result item
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= cur;
            line_reg <= head.line;
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = res_reg.kind;
    assign out_byte  = res_reg.data;
    assign out_line  = line_reg;
    assign out_cmd   = res_reg.cmd;
    assign out_last  = last_reg;

endmodule

// ===== hw/rtl/script_word_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Script word tokenizer
// Splits script text, one byte per item, into word bytes, word ends and an
// end-of-text marker.
// ----------------------------------------------------------------------------
// It takes one text byte per cycle while s_tready is high and gives one result item per cycle while m_tready is high.
// A byte causes zero to three results (for a lone slash followed by the end of
// text: the slash, the word end and the end marker); the front end keeps
// taking bytes while the back end drains a multi-result byte, and the
// four-entry bundle queue between them sets how long such a burst can run
// before s_tready drops. An accepted byte's first result passes the queue write,
// then the output register. The line counter is LINE_BITS wide and saturates;
// m_tdata carries its low 16 bits.
`include "script_word_tokenizer_defines.svh"

module script_word_tokenizer import swt_pkg::*; #(
    parameter int unsigned LINE_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] in_byte
    input  logic         s_tlast,    // end_of_buffer
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,    // [7:0] word_byte, [23:8] line_num
    output logic [2:0]   m_tuser,    // [1:0] kind, [2] is_command
    output logic         m_tlast     // last
);

    q_stat_t                q_stat;
    logic                   push_valid;
    bundle_t                push_data;
    bundle_t                head;
    logic                   pop;
    kind_t                  out_kind;
    logic [BYTE_W-1:0]      out_byte;
    logic [LINE_W-1:0]      out_line;
    logic                   out_cmd;

    // Accept and tokenize
    swt_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_eob     (s_tlast),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // Buffer result bundles
    swt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // Serialize results
    swt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_line  (out_line),
        .out_cmd   (out_cmd),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_line, out_byte};
    assign m_tuser = {out_cmd, out_kind};

    // End-of-text marker always closes the results of its byte
    `SWT_ASSERT_IMP(a_end_is_last, aclk, aresetn, m_tvalid && (out_kind == KIND_END), m_tlast, "end marker without tlast")
    // Only word bytes carry a character
    `SWT_ASSERT_IMP(a_marker_no_byte, aclk, aresetn, m_tvalid && (out_kind != KIND_BYTE), out_byte == CH_NUL, "marker with nonzero byte")
    // Command flag appears on word ends alone
    `SWT_ASSERT_IMP(a_cmd_on_wend, aclk, aresetn, m_tvalid && out_cmd, out_kind == KIND_WEND, "command flag off a word end")
    // A bundle is never pushed into a full queue
    `SWT_ASSERT_IMP(a_no_overflow, aclk, aresetn, push_valid, !q_stat.full, "push into full queue")

endmodule
